// ===== hw/rtl/vmvt_pkg.sv =====
// Shared constants for the vertex transform pipeline.
`default_nettype none
package vmvt_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 32;
    localparam int CLIP_W        = 66;
    localparam int SIZE_W        = 14;
    localparam int CFG_IDX_W     = 1;
    localparam int MAT_LAT       = 2;
    localparam int DIV_LAT       = 34;
    localparam int VP_LAT        = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd480;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_VERTEX = 1'b1;
endpackage
`default_nettype wire

// ===== hw/rtl/vmvt_in_if.sv =====
// Input channel: one load or vertex beat.
`default_nettype none
interface vmvt_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [31:0] vertex_w;
    modport source (output valid, action, coeff_index, coeff_value,
                    vertex_x, vertex_y, vertex_z, vertex_w, input ready);
    modport sink   (input valid, action, coeff_index, coeff_value,
                    vertex_x, vertex_y, vertex_z, vertex_w, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vmvt_out_if.sv =====
// Output channel: one screen-space result beat.
`default_nettype none
interface vmvt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_z;
    logic               w_zero_error;
    modport source (output valid, screen_x, screen_y, screen_z, w_zero_error,
                    input ready);
    modport sink   (input valid, screen_x, screen_y, screen_z, w_zero_error,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vmvt_mat.sv =====
// Coefficient store and 4x4 matrix-vector product, two stages.
`default_nettype none
module vmvt_mat #(
    parameter int FRAC_BITS = vmvt_pkg::FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire                                  i_load,
    input  wire                                  i_vert,
    input  wire  [3:0]                           i_idx,
    input  wire  signed [31:0]                   i_coeff,
    input  wire  signed [31:0]                   i_v [4],
    output logic                                 o_valid,
    output logic signed [vmvt_pkg::CLIP_W-1:0]   o_clip [4]
);
    localparam int CW = vmvt_pkg::CLIP_W;

    logic signed [31:0]  r_mat [16];
    logic signed [63:0]  r_p [16];
    logic                r_pv;
    logic                r_cv;
    logic signed [CW-1:0] r_clip [4];
    logic signed [CW-1:0] n_clip [4];

    // coefficient store, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= ((i >> 2) == (i & 3)) ? 32'(64'd1 << FRAC_BITS) : 32'sd0;
            end
        end else if (i_load) begin
            r_mat[i_idx] <= i_coeff;
        end
    end

    // row sums of floored products
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_clip[r] = '0;
            for (int c = 0; c < 4; c++) begin
                n_clip[r] = n_clip[r] + CW'(r_p[r*4+c] >>> FRAC_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_cv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_vert;
            r_cv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 16; k++) begin
                r_p[k] <= 64'(r_mat[k]) * 64'(i_v[k & 3]);
            end
            for (int r = 0; r < 4; r++) begin
                r_clip[r] <= n_clip[r];
            end
        end
    end

    assign o_valid = r_cv;
    assign o_clip  = r_clip;
endmodule
`default_nettype wire

// ===== hw/rtl/vmvt_div.sv =====
// Pipelined restoring divider: num * 2^F / den, toward zero, saturated.
`default_nettype none
module vmvt_div #(
    parameter int FRAC_BITS = vmvt_pkg::FRAC_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire  signed [vmvt_pkg::CLIP_W-1:0]  i_num,
    input  wire  signed [vmvt_pkg::CLIP_W-1:0]  i_den,
    output logic signed [31:0]                  o_q
);
    localparam int CW = vmvt_pkg::CLIP_W;
    localparam int RW = CW + 32;
    localparam int QB = 31;

    logic [CW-1:0] n_un, n_ud;
    logic [RW-1:0] r_n0;
    logic [CW-1:0] r_d0;
    logic          r_neg0;
    logic [RW-1:0] r_rem [QB+1];
    logic [CW-1:0] r_d   [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_sat [QB+1];
    logic          r_neg [QB+1];
    logic [RW-1:0] n_trial [QB];
    logic [31:0]   n_mag;
    logic signed [31:0] r_res;

    assign n_un = i_num[CW-1] ? CW'(-i_num) : CW'(i_num);
    assign n_ud = i_den[CW-1] ? CW'(-i_den) : CW'(i_den);

    always_comb begin
        for (int j = 0; j < QB; j++) begin
            n_trial[j] = RW'(r_d[j]) << (QB - 1 - j);
        end
    end

    assign n_mag = {1'b0, r_q[QB]};

    // magnitude, overflow check, one quotient bit per stage, sign fixup
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n0   <= RW'(n_un) << FRAC_BITS;
            r_d0   <= n_ud;
            r_neg0 <= i_num[CW-1] ^ i_den[CW-1];
            r_rem[0] <= r_n0;
            r_d[0]   <= r_d0;
            r_q[0]   <= '0;
            r_sat[0] <= r_n0 >= (RW'(r_d0) << QB);
            r_neg[0] <= r_neg0;
            for (int j = 0; j < QB; j++) begin
                r_d[j+1]   <= r_d[j];
                r_sat[j+1] <= r_sat[j];
                r_neg[j+1] <= r_neg[j];
                if (r_rem[j] >= n_trial[j]) begin
                    r_rem[j+1] <= r_rem[j] - n_trial[j];
                    r_q[j+1]   <= {r_q[j][QB-2:0], 1'b1};
                end else begin
                    r_rem[j+1] <= r_rem[j];
                    r_q[j+1]   <= {r_q[j][QB-2:0], 1'b0};
                end
            end
            if (r_sat[QB]) begin
                r_res <= r_neg[QB] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                r_res <= r_neg[QB] ? -$signed(n_mag) : $signed(n_mag);
            end
        end
    end

    assign o_q = r_res;
endmodule
`default_nettype wire

// ===== hw/rtl/vmvt_vp.sv =====
// Viewport map: (ndc * size + size * 2^F) >> 1, saturated; two stages.
`default_nettype none
module vmvt_vp #(
    parameter int FRAC_BITS = vmvt_pkg::FRAC_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_en,
    input  wire  signed [31:0]                i_ndc,
    input  wire  [vmvt_pkg::SIZE_W-1:0]       i_size,
    output logic signed [31:0]                o_s
);
    localparam int SW = vmvt_pkg::SIZE_W;

    logic signed [46:0] r_prod;
    logic [SW-1:0]      r_size;
    logic signed [47:0] n_off, n_sum;
    logic signed [31:0] r_s;

    assign n_off = $signed({{(48-SW){1'b0}}, r_size}) <<< FRAC_BITS;
    assign n_sum = (48'(r_prod) + n_off) >>> 1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 47'(i_ndc) * 47'($signed({1'b0, i_size}));
            r_size <= i_size;
            if (n_sum > 48'sh0000_7fff_ffff) begin
                r_s <= 32'sh7fff_ffff;
            end else if (n_sum < -48'sh0000_8000_0000) begin
                r_s <= 32'sh8000_0000;
            end else begin
                r_s <= 32'(n_sum);
            end
        end
    end

    assign o_s = r_s;
endmodule
`default_nettype wire

// ===== hw/rtl/vertex_mvp_viewport_transform_top.sv =====
// Top level of the vertex transform pipeline.
// Usage:
//   i_vtx carries load beats (action 0: write one matrix coefficient) and
//   vertex beats (action 1). o_pix carries one result per vertex beat, in
//   order. Loads take effect for every vertex accepted after them.
//   The config port writes viewport width (index 0) and height (index 1);
//   write only while no vertex is in flight.
// Timing:
//   An accepted vertex beat passes through the matrix product, the pipelined
//   divider (one quotient bit per stage over 31 stages) and the viewport map
//   before its result appears on o_pix.
//   Throughput is one beat per cycle while the output is not stalled.
// Reset:
//   Synchronous active-low reset clears all valid bits, restores the
//   identity matrix and a 640 x 480 viewport.
// Backpressure:
//   The whole pipeline advances only when the output register is empty or
//   being taken; a stall freezes every stage and i_vtx.ready drops.
`default_nettype none
module vertex_mvp_viewport_transform_top #(
    parameter int FRAC_BITS = vmvt_pkg::FRAC_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [vmvt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [vmvt_pkg::SIZE_W-1:0]         i_cfg_data,
    vmvt_in_if.sink                             i_vtx,
    vmvt_out_if.source                          o_pix
);
    localparam int CW  = vmvt_pkg::CLIP_W;
    localparam int TOT = vmvt_pkg::DIV_LAT + vmvt_pkg::VP_LAT;

    logic                     w_adv;
    logic                     w_acc;
    logic signed [31:0]       w_v [4];
    logic                     w_cv;
    logic signed [CW-1:0]     w_clip [4];
    logic signed [31:0]       w_qx, w_qy, w_qz, w_sx, w_sy;
    logic [vmvt_pkg::SIZE_W-1:0] r_width, r_height;
    logic [TOT-1:0]           r_vld;
    logic [TOT-1:0]           r_wz;
    logic signed [31:0]       r_z [vmvt_pkg::VP_LAT];

    // global advance: output register empty or draining
    assign w_adv       = !r_vld[TOT-1] || o_pix.ready;
    assign i_vtx.ready = w_adv;
    assign w_acc       = i_vtx.valid && w_adv;
    assign w_v[0] = i_vtx.vertex_x;
    assign w_v[1] = i_vtx.vertex_y;
    assign w_v[2] = i_vtx.vertex_z;
    assign w_v[3] = i_vtx.vertex_w;

    // viewport registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= vmvt_pkg::WIDTH_RST;
            r_height <= vmvt_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vmvt_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                vmvt_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vmvt_mat #(.FRAC_BITS(FRAC_BITS)) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_load  (w_acc && i_vtx.action == vmvt_pkg::ACT_LOAD),
        .i_vert  (w_acc && i_vtx.action == vmvt_pkg::ACT_VERTEX),
        .i_idx   (i_vtx.coeff_index),
        .i_coeff (i_vtx.coeff_value),
        .i_v     (w_v),
        .o_valid (w_cv),
        .o_clip  (w_clip)
    );

    vmvt_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_clip[0]), .i_den(w_clip[3]), .o_q(w_qx));
    vmvt_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_clip[1]), .i_den(w_clip[3]), .o_q(w_qy));
    vmvt_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_clip[2]), .i_den(w_clip[3]), .o_q(w_qz));

    vmvt_vp #(.FRAC_BITS(FRAC_BITS)) u_vp_x (
        .i_clk(i_clk), .i_en(w_adv), .i_ndc(w_qx), .i_size(r_width), .o_s(w_sx));
    vmvt_vp #(.FRAC_BITS(FRAC_BITS)) u_vp_y (
        .i_clk(i_clk), .i_en(w_adv), .i_ndc(w_qy), .i_size(r_height), .o_s(w_sy));

    // valid and zero-w flags travel alongside the divider and viewport stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[TOT-2:0], w_cv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wz <= {r_wz[TOT-2:0], (w_clip[3] == '0)};
            r_z[0] <= w_qz;
            for (int i = 1; i < vmvt_pkg::VP_LAT; i++) begin
                r_z[i] <= r_z[i-1];
            end
        end
    end

    // result beat, zeroed on zero w
    assign o_pix.valid        = r_vld[TOT-1];
    assign o_pix.w_zero_error = r_wz[TOT-1];
    assign o_pix.screen_x     = r_wz[TOT-1] ? 32'sd0 : w_sx;
    assign o_pix.screen_y     = r_wz[TOT-1] ? 32'sd0 : w_sy;
    assign o_pix.screen_z     = r_wz[TOT-1] ? 32'sd0 : r_z[vmvt_pkg::VP_LAT-1];

    // a stalled pipeline holds its valid bits
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid bits moved during stall");

    // zero-w results carry zero coordinates
    a_wz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && o_pix.w_zero_error |->
            o_pix.screen_x == 0 && o_pix.screen_y == 0 && o_pix.screen_z == 0)
        else $error("zero-w result not cleared");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid && r_vld == '0)
        else $error("pipeline not empty after reset");
endmodule
`default_nettype wire

// ===== tb/tb_vertex_mvp_viewport_transform_top.sv =====
// Testbench for the vertex transform top: predicts each screen result and checks it.
`timescale 1ns / 100ps
`default_nettype none
module tb_vertex_mvp_viewport_transform_top;

    localparam int FB        = vmvt_pkg::FRAC_BITS_DEF;
    localparam int CYC_LIMIT = 2000000;
    localparam int SETTLE    = 60;

    typedef struct {
        logic               action;
        logic [3:0]         idx;
        logic signed [31:0] coef;
        logic signed [31:0] x, y, z, w;
    } t_vtx_beat;

    typedef struct {
        logic signed [31:0] sx, sy, sz;
        logic               werr;
    } t_pix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [vmvt_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [vmvt_pkg::SIZE_W-1:0] i_cfg_data = '0;

    vmvt_in_if  vtx ();
    vmvt_out_if pix ();

    vertex_mvp_viewport_transform_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vtx      (vtx.sink),
        .o_pix      (pix.source)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0]          mat [16];
    logic [vmvt_pkg::SIZE_W-1:0] vp_w, vp_h;

    t_vtx_beat pend_q [$];
    t_pix      pix_q  [$];
    int        errors = 0;
    int        cycles = 0;
    int        stall_pct = 0;
    int        gap_max = 0;
    int        n_pix = 0;

    // perspective divide: n * 2^FB / d, truncated toward zero, saturated
    function automatic logic signed [31:0] ndc_div(longint n, longint d);
        logic [127:0] un, ud, q;
        logic neg;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? 128'(-n) : 128'(n);
        ud = (d < 0) ? 128'(-d) : 128'(d);
        q = (un << FB) / ud;
        if (!neg)
            return (q > 128'h7fffffff) ? 32'h7fffffff : q[31:0];
        return (q >= 128'h80000000) ? 32'h80000000 : -q[31:0];
    endfunction

    function automatic logic signed [31:0] vp_map(logic signed [31:0] ndc,
                                                 logic [vmvt_pkg::SIZE_W-1:0] size);
        longint s;
        longint sum;
        s = longint'(size);
        sum = longint'(ndc) * s + (s <<< FB);
        sum = sum >>> 1;
        if (sum > 64'sd2147483647) return 32'h7fffffff;
        if (sum < -64'sd2147483648) return 32'h80000000;
        return sum[31:0];
    endfunction

    function automatic t_pix xform(t_vtx_beat b);
        longint v [4];
        longint clip [4];
        t_pix r;
        v[0] = b.x; v[1] = b.y; v[2] = b.z; v[3] = b.w;
        for (int row = 0; row < 4; row++) begin
            clip[row] = 0;
            for (int col = 0; col < 4; col++)
                clip[row] += (longint'(mat[row*4+col]) * v[col]) >>> FB;
        end
        if (clip[3] == 0) begin
            r.sx = '0; r.sy = '0; r.sz = '0; r.werr = 1'b1;
        end else begin
            r.sx = vp_map(ndc_div(clip[0], clip[3]), vp_w);
            r.sy = vp_map(ndc_div(clip[1], clip[3]), vp_h);
            r.sz = ndc_div(clip[2], clip[3]);
            r.werr = 1'b0;
        end
        return r;
    endfunction

    // track accepted beats and config writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++)
                mat[i] = (i % 5 == 0) ? (32'sd1 <<< FB) : 32'sd0;
            vp_w = vmvt_pkg::WIDTH_RST;
            vp_h = vmvt_pkg::HEIGHT_RST;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == vmvt_pkg::REG_WIDTH) vp_w = i_cfg_data;
                else if (i_cfg_idx == vmvt_pkg::REG_HEIGHT) vp_h = i_cfg_data;
            end
            if (vtx.valid && vtx.ready) begin
                if (vtx.action == vmvt_pkg::ACT_LOAD)
                    mat[vtx.coeff_index] = vtx.coeff_value;
                else
                    pix_q.push_back(xform('{vtx.action, vtx.coeff_index,
                        vtx.coeff_value, vtx.vertex_x, vtx.vertex_y,
                        vtx.vertex_z, vtx.vertex_w}));
            end
        end
    end

    // driver: bursts of random length, random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_vtx_beat b;
        if (!i_rst_n) begin
            vtx.valid <= 1'b0;
            vtx.action <= vmvt_pkg::ACT_LOAD;
            vtx.coeff_index <= '0;
            vtx.coeff_value <= '0;
            vtx.vertex_x <= '0;
            vtx.vertex_y <= '0;
            vtx.vertex_z <= '0;
            vtx.vertex_w <= '0;
        end else if (!vtx.valid || vtx.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                vtx.valid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                b = pend_q.pop_front();
                vtx.valid <= 1'b1;
                vtx.action <= b.action;
                vtx.coeff_index <= b.idx;
                vtx.coeff_value <= b.coef;
                vtx.vertex_x <= b.x;
                vtx.vertex_y <= b.y;
                vtx.vertex_z <= b.z;
                vtx.vertex_w <= b.w;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
                end else begin
                    burst_left--;
                end
            end else begin
                vtx.valid <= 1'b0;
            end
        end
    end

    // monitor: stall pattern, one long hold-off, field checks
    int hold_left = 0;
    logic long_done = 1'b0;
    always @(posedge i_clk) begin
        t_pix e;
        if (!i_rst_n) begin
            pix.ready <= 1'b0;
        end else begin
            if (pix.valid && pix.ready) begin
                n_pix++;
                if (pix_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat x=%h y=%h z=%h err=%b", $time,
                             pix.screen_x, pix.screen_y, pix.screen_z, pix.w_zero_error);
                end else begin
                    e = pix_q.pop_front();
                    if (pix.screen_x !== e.sx || pix.screen_y !== e.sy ||
                        pix.screen_z !== e.sz || pix.w_zero_error !== e.werr) begin
                        errors++;
                        $display("%0t: mismatch expected x=%h y=%h z=%h err=%b", $time,
                                 e.sx, e.sy, e.sz, e.werr);
                        $display("%0t:          actual   x=%h y=%h z=%h err=%b", $time,
                                 pix.screen_x, pix.screen_y, pix.screen_z,
                                 pix.w_zero_error);
                    end
                end
            end
            if (!long_done && n_pix == 300) begin
                long_done <= 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                pix.ready <= 1'b0;
            end else begin
                pix.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("FAIL vertex_mvp_viewport_transform_top");
            $finish;
        end
    end

    function automatic logic signed [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 8 << FB)) - (32'sd4 <<< FB);
            2: return ($signed($urandom_range(0, 8)) - 4) <<< FB;
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $signed($urandom_range(0, 2 << FB)) - (32'sd1 <<< FB);
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_coef();
        if ($urandom_range(0, 9) == 0) return $urandom;
        if ($urandom_range(0, 3) == 0) return '0;
        return $signed($urandom_range(0, 4 << FB)) - (32'sd2 <<< FB);
    endfunction

    task automatic put_load(int idx, logic signed [31:0] c);
        pend_q.push_back('{vmvt_pkg::ACT_LOAD, 4'(idx), c,
                           $urandom, $urandom, $urandom, $urandom});
    endtask

    task automatic put_vertex(logic signed [31:0] x, y, z, w);
        pend_q.push_back('{vmvt_pkg::ACT_VERTEX, 4'($urandom), $urandom, x, y, z, w});
    endtask

    // sample at the falling edge so every clocked update has settled
    task automatic drain();
        @(negedge i_clk);
        while (pend_q.size() > 0 || vtx.valid || pix_q.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [vmvt_pkg::CFG_IDX_W-1:0] idx,
                             logic [vmvt_pkg::SIZE_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random phase: matrix sets followed by vertex runs, plus stray loads
    task automatic random_phase(int n);
        int cnt;
        cnt = 0;
        while (cnt < n) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    for (int i = 0; i < 16; i++) put_load(i, rnd_coef());
                    if ($urandom_range(0, 1)) begin
                        // perspective-like last row: w = -z
                        put_load(12, 0); put_load(13, 0);
                        put_load(14, -(32'sd1 <<< FB)); put_load(15, 0);
                    end
                    cnt += 16;
                end
                2: begin
                    put_load($urandom_range(0, 15), rnd_coef());
                    cnt++;
                end
                default: begin
                    repeat ($urandom_range(1, 20)) begin
                        put_vertex(rnd_val(), rnd_val(), rnd_val(),
                                   ($urandom_range(0, 19) == 0) ? 32'sd0 : rnd_val());
                        cnt++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        pix.ready = 1'b0;
        vtx.valid = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity matrix, reset viewport
        put_vertex(0, 0, 0, 32'sd1 <<< FB);
        put_vertex(32'sd1 <<< FB, -(32'sd1 <<< FB), 32'sd1 <<< 15, 32'sd1 <<< FB);
        put_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'sd1);
        put_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, -32'sd1);
        put_vertex(32'sd5 <<< FB, 32'sd3 <<< FB, 32'sd7 <<< FB, 32'h80000000);
        put_vertex(32'sd5 <<< FB, 32'sd3 <<< FB, 32'sd1, 32'sd0);
        put_vertex(32'sd3 <<< FB, 32'sd3 <<< FB, 32'sd3 <<< FB, -(32'sd2 <<< FB));
        // every coefficient loaded, extremes included
        for (int i = 0; i < 16; i++)
            put_load(i, (i % 2) ? 32'h80000000 : 32'h7fffffff);
        put_vertex(32'sd1 <<< FB, 32'sd1 <<< FB, 32'sd1 <<< FB, 32'sd1 <<< FB);
        // zero last row: w is exactly zero
        put_load(12, 0); put_load(13, 0); put_load(14, 0); put_load(15, 0);
        put_vertex(32'sd2 <<< FB, 32'sd2 <<< FB, 32'sd2 <<< FB, 32'sd2 <<< FB);
        drain();

        // sweep viewport settings, extremes and zero among them
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    cfg_write(vmvt_pkg::REG_WIDTH, 14'd1);
                    cfg_write(vmvt_pkg::REG_HEIGHT, 14'd1);
                end
                1: begin
                    cfg_write(vmvt_pkg::REG_WIDTH, 14'd8192);
                    cfg_write(vmvt_pkg::REG_HEIGHT, 14'd8192);
                end
                2: begin
                    cfg_write(vmvt_pkg::REG_WIDTH, 14'd0);
                    cfg_write(vmvt_pkg::REG_HEIGHT, 14'h3fff);
                end
                3: begin
                    cfg_write(vmvt_pkg::REG_WIDTH, 14'h3fff);
                    cfg_write(vmvt_pkg::REG_HEIGHT, 14'd0);
                end
                default: begin
                    cfg_write(vmvt_pkg::REG_WIDTH, 14'($urandom));
                    cfg_write(vmvt_pkg::REG_HEIGHT, 14'($urandom));
                end
            endcase
            stall_pct = (ph == 1) ? 0 : $urandom_range(0, 60);
            gap_max = (ph == 1) ? 0 : $urandom_range(0, 8);
            random_phase(320);
            drain();
        end

        if (errors == 0)
            $display("PASS vertex_mvp_viewport_transform_top");
        else
            $display("FAIL vertex_mvp_viewport_transform_top");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/vmvt_pkg.sv
hw/rtl/vmvt_in_if.sv
hw/rtl/vmvt_out_if.sv
hw/rtl/vmvt_mat.sv
hw/rtl/vmvt_div.sv
hw/rtl/vmvt_vp.sv
hw/rtl/vertex_mvp_viewport_transform_top.sv
tb/tb_vertex_mvp_viewport_transform_top.sv
